[rtl/assert_macros.svh]
// Assertion helpers shared by the sequencer RTL.
// Each macro expands to one labeled concurrent assertion, clocked on the rising edge
// and disabled while the active-low reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion violated");

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion violated");

// The condition never holds.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("assertion violated");

`endif

[rtl/pbgas_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbgas_pkg
// Shared types, codes and helper functions of the brightness/gamma/current
// limit command sequencer.
// ----------------------------------------------------------------------------
package pbgas_pkg;

    // Highest gamma level of the panel tables.
    localparam int MAX_GAMMA_INDEX = 24;
    localparam int BL_MIN          = 30;
    localparam int BL_MAX          = 255;
    localparam int BL_SPAN         = BL_MAX - BL_MIN;

    // Level mapping: level = floor((K*b + SPAN*(C+5)) / (10*SPAN)), evaluated
    // as a multiply by a rounded-up reciprocal and a shift.
    localparam int     GAMMA_K   = 10 * (MAX_GAMMA_INDEX - 1);
    localparam int     GAMMA_C   = 10 - (GAMMA_K * BL_MIN) / BL_SPAN;
    localparam int     LVL_DIV   = 10 * BL_SPAN;
    localparam int     LVL_SHIFT = 32;
    localparam int     LVL_W     = 48;
    localparam longint LVL_RECIP = ((longint'(1) <<< LVL_SHIFT) + LVL_DIV - 1) / LVL_DIV;
    localparam logic [LVL_W-1:0] LVL_MUL = LVL_W'(longint'(GAMMA_K) * LVL_RECIP);
    localparam logic [LVL_W-1:0] LVL_ADD =
        LVL_W'(longint'(BL_SPAN * (GAMMA_C + 5)) * LVL_RECIP);

    // Event codes.
    localparam logic [1:0] OP_BRIGHT = 2'd0;
    localparam logic [1:0] OP_CURVE  = 2'd1;
    localparam logic [1:0] OP_LIMIT  = 2'd2;

    // Panel command codes.
    localparam logic [2:0] CMD_OFF    = 3'd0;
    localparam logic [2:0] CMD_TABLE  = 3'd1;
    localparam logic [2:0] CMD_UPDATE = 3'd2;
    localparam logic [2:0] CMD_INIT   = 3'd3;
    localparam logic [2:0] CMD_CUTOFF = 3'd4;

    // Current limit percentages and cutoff table indexes.
    localparam logic [5:0] PCT_OFF = 6'd0;
    localparam logic [5:0] PCT_DIM = 6'd20;
    localparam logic [4:0] IDX_DIM = 5'd3;
    localparam logic [4:0] IDX_OFF = 5'd0;

    // Command queue between the front and back parts.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);
    localparam logic [QCNT_W-1:0] QCNT_FULL = QCNT_W'(QDEPTH);
    localparam logic [QPTR_W-1:0] QPTR_LAST = QPTR_W'(QDEPTH - 1);

    typedef struct packed {
        logic [2:0] command;
        logic       curve_19;
        logic [4:0] table_index;
    } t_cmd;

    // Up to three commands caused by one event.
    typedef struct packed {
        logic [1:0]     cnt;
        t_cmd [2:0]     cmds;
    } t_bundle;

    typedef struct packed {
        logic    push;
        t_bundle bundle;
    } t_push;

    typedef struct packed {
        logic    valid;
        t_bundle bundle;
    } t_qhead;

    typedef struct packed {
        logic [5:0] pct;
        logic [4:0] idx;
    } t_cutoff;

    function automatic t_cmd mk_cmd(input logic [2:0] cmd, input logic curve,
                                    input logic [4:0] idx);
        t_cmd c;
        c.command     = cmd;
        c.curve_19    = curve;
        c.table_index = idx;
        return c;
    endfunction

    function automatic t_cutoff pick_cutoff(input logic valid, input logic [4:0] lvl);
        t_cutoff c;
        c.pct = 6'd50;
        c.idx = 5'd13;
        if (valid) begin
            if (lvl <= 5'd1) begin
                c.pct = PCT_DIM;
                c.idx = IDX_DIM;
            end else if (lvl <= 5'd12) begin
                c.pct = 6'd40;
                c.idx = 5'd9;
            end else if (lvl == 5'd13) begin
                c.pct = 6'd43;
                c.idx = 5'd16;
            end else if (lvl == 5'd14) begin
                c.pct = 6'd45;
                c.idx = 5'd10;
            end else if (lvl == 5'd15) begin
                c.pct = 6'd47;
                c.idx = 5'd11;
            end else if (lvl == 5'd16) begin
                c.pct = 6'd48;
                c.idx = 5'd12;
            end
        end
        return c;
    endfunction

    // Gamma level for a brightness of BL_MIN or more.
    function automatic logic [4:0] level_of(input logic [7:0] b);
        logic [LVL_W-1:0] prod;
        prod = LVL_W'(b) * LVL_MUL + LVL_ADD;
        return prod[LVL_SHIFT +: 5];
    endfunction

endpackage

[rtl/pbgas_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbgas_front
// Accepts events, updates the panel state and builds the command list that
// each event causes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pbgas_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [1:0]             i_op,
    input  logic [7:0]             i_brightness,
    input  logic [7:0]             i_setting,
    input  logic                   i_full,
    output pbgas_pkg::t_push       o_push
);

    logic       r_gvalid, n_gvalid;
    logic [4:0] r_glevel, n_glevel;
    logic [5:0] r_pct,    n_pct;
    logic       r_curve,  n_curve;
    logic       r_en,     n_en;

    logic                take;
    logic                dim;
    logic                set_ok;
    logic [4:0]          lvl;
    logic [1:0]          n;
    pbgas_pkg::t_cutoff  cut_new;
    pbgas_pkg::t_cutoff  cut_cur;
    pbgas_pkg::t_bundle  bundle;

    assign o_ready = !i_full;
    assign take    = i_valid && o_ready;
    assign dim     = i_brightness < 8'(pbgas_pkg::BL_MIN);
    assign set_ok  = i_setting[7:1] == 7'd0;
    assign lvl     = dim ? 5'd0 : pbgas_pkg::level_of(i_brightness);
    assign cut_new = pbgas_pkg::pick_cutoff(1'b1, lvl);
    assign cut_cur = pbgas_pkg::pick_cutoff(r_gvalid, r_glevel);

    always_comb begin
        n_gvalid = r_gvalid;
        n_glevel = r_glevel;
        n_pct    = r_pct;
        n_curve  = r_curve;
        n_en     = r_en;
        n        = 2'd0;
        bundle   = '0;
        if (take) begin
            unique case (i_op)
                pbgas_pkg::OP_BRIGHT: begin
                    if (i_brightness == 8'd0) begin
                        bundle.cmds[n] = pbgas_pkg::mk_cmd(pbgas_pkg::CMD_OFF, 1'b0, 5'd0);
                        n = n + 2'd1;
                        n_gvalid = 1'b0;
                    end else if (!(r_gvalid && r_glevel == lvl)) begin
                        if (dim) begin
                            if (r_en) begin
                                if (r_pct == pbgas_pkg::PCT_OFF) begin
                                    bundle.cmds[n] = pbgas_pkg::mk_cmd(
                                        pbgas_pkg::CMD_INIT, 1'b0, 5'd0);
                                    n = n + 2'd1;
                                end
                                if (r_pct != pbgas_pkg::PCT_DIM) begin
                                    bundle.cmds[n] = pbgas_pkg::mk_cmd(
                                        pbgas_pkg::CMD_CUTOFF, 1'b0, pbgas_pkg::IDX_DIM);
                                    n = n + 2'd1;
                                    n_pct = pbgas_pkg::PCT_DIM;
                                end
                            end
                            bundle.cmds[n] = pbgas_pkg::mk_cmd(
                                pbgas_pkg::CMD_TABLE, r_curve, 5'd0);
                            n = n + 2'd1;
                        end else begin
                            bundle.cmds[n] = pbgas_pkg::mk_cmd(
                                pbgas_pkg::CMD_TABLE, r_curve, lvl);
                            n = n + 2'd1;
                            if (r_en) begin
                                if (r_pct == pbgas_pkg::PCT_OFF) begin
                                    bundle.cmds[n] = pbgas_pkg::mk_cmd(
                                        pbgas_pkg::CMD_INIT, 1'b0, 5'd0);
                                    n = n + 2'd1;
                                end
                                if (r_pct != cut_new.pct) begin
                                    bundle.cmds[n] = pbgas_pkg::mk_cmd(
                                        pbgas_pkg::CMD_CUTOFF, 1'b0, cut_new.idx);
                                    n = n + 2'd1;
                                    n_pct = cut_new.pct;
                                end
                            end
                        end
                        n_glevel = lvl;
                        n_gvalid = 1'b1;
                    end
                end
                pbgas_pkg::OP_CURVE: begin
                    if (set_ok && i_setting[0] != r_curve) begin
                        n_curve = i_setting[0];
                        if (r_gvalid) begin
                            bundle.cmds[n] = pbgas_pkg::mk_cmd(
                                pbgas_pkg::CMD_TABLE, i_setting[0], r_glevel);
                            n = n + 2'd1;
                            bundle.cmds[n] = pbgas_pkg::mk_cmd(
                                pbgas_pkg::CMD_UPDATE, 1'b0, 5'd0);
                            n = n + 2'd1;
                        end
                    end
                end
                pbgas_pkg::OP_LIMIT: begin
                    if (set_ok && i_setting[0] != r_en) begin
                        n_en = i_setting[0];
                        if (i_setting[0]) begin
                            bundle.cmds[n] = pbgas_pkg::mk_cmd(
                                pbgas_pkg::CMD_INIT, 1'b0, 5'd0);
                            n = n + 2'd1;
                            bundle.cmds[n] = pbgas_pkg::mk_cmd(
                                pbgas_pkg::CMD_CUTOFF, 1'b0, cut_cur.idx);
                            n = n + 2'd1;
                            n_pct = cut_cur.pct;
                        end else begin
                            bundle.cmds[n] = pbgas_pkg::mk_cmd(
                                pbgas_pkg::CMD_CUTOFF, 1'b0, pbgas_pkg::IDX_OFF);
                            n = n + 2'd1;
                            n_pct = pbgas_pkg::PCT_OFF;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        bundle.cnt = n;
    end

    assign o_push.push   = take && (n != 2'd0);
    assign o_push.bundle = bundle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gvalid <= 1'b0;
            r_glevel <= 5'd0;
            r_pct    <= pbgas_pkg::PCT_OFF;
            r_curve  <= 1'b0;
            r_en     <= 1'b0;
        end else begin
            r_gvalid <= n_gvalid;
            r_glevel <= n_glevel;
            r_pct    <= n_pct;
            r_curve  <= n_curve;
            r_en     <= n_en;
        end
    end

    // A display-off event always leaves no gamma applied.
    `ASSERT_NEXT(a_off_clears_gamma, i_clk, i_rst_n, take && i_op == pbgas_pkg::OP_BRIGHT && i_brightness == 8'd0, !r_gvalid)
    // The limit percentage is zero exactly when limiting is off.
    `ASSERT_IMPLIES(a_pct_tracks_en, i_clk, i_rst_n, 1'b1, r_en == (r_pct != pbgas_pkg::PCT_OFF))

endmodule

[rtl/pbgas_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbgas_queue
// Small FIFO of command lists between the front and back parts.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pbgas_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pbgas_pkg::t_push    i_push,
    input  logic                i_pop,
    output logic                o_full,
    output pbgas_pkg::t_qhead   o_head
);

    pbgas_pkg::t_bundle                  r_mem [pbgas_pkg::QDEPTH];
    logic [pbgas_pkg::QPTR_W-1:0]        r_wr, r_rd;
    logic [pbgas_pkg::QCNT_W-1:0]        r_count;

    assign o_full        = r_count == pbgas_pkg::QCNT_FULL;
    assign o_head.valid  = r_count != '0;
    assign o_head.bundle = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wr] <= i_push.bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push.push) begin
                r_wr <= (r_wr == pbgas_pkg::QPTR_LAST) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == pbgas_pkg::QPTR_LAST) ? '0 : r_rd + 1'b1;
            end
            case ({i_push.push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    `ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n, i_push.push && o_full && !i_pop)
    `ASSERT_NEVER(a_no_underflow, i_clk, i_rst_n, i_pop && r_count == '0)

endmodule

[rtl/pbgas_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbgas_back
// Takes command lists from the queue and issues them one command per cycle
// while the receiver is ready, through a registered output.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pbgas_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pbgas_pkg::t_qhead   i_head,
    output logic                o_pop,
    input  logic                i_ready,
    output logic                o_valid,
    output pbgas_pkg::t_cmd     o_cmd,
    output logic                o_last
);

    logic               r_busy,   n_busy;
    logic [1:0]         r_pos,    n_pos;
    pbgas_pkg::t_bundle r_bundle, n_bundle;
    logic               r_ovalid, n_ovalid;
    pbgas_pkg::t_cmd    r_out,    n_out;
    logic               r_last,   n_last;
    logic               load;

    assign load = !r_ovalid || i_ready;

    always_comb begin
        n_busy   = r_busy;
        n_pos    = r_pos;
        n_bundle = r_bundle;
        n_ovalid = r_ovalid;
        n_out    = r_out;
        n_last   = r_last;
        o_pop    = 1'b0;
        if (load) begin
            n_ovalid = 1'b0;
            if (r_busy) begin
                n_out    = r_bundle.cmds[r_pos];
                n_ovalid = 1'b1;
                if (r_pos == r_bundle.cnt - 2'd1) begin
                    n_last = 1'b1;
                    n_busy = 1'b0;
                end else begin
                    n_last = 1'b0;
                    n_pos  = r_pos + 2'd1;
                end
            end else if (i_head.valid) begin
                n_out    = i_head.bundle.cmds[0];
                n_ovalid = 1'b1;
                o_pop    = 1'b1;
                if (i_head.bundle.cnt == 2'd1) begin
                    n_last = 1'b1;
                end else begin
                    n_last   = 1'b0;
                    n_busy   = 1'b1;
                    n_bundle = i_head.bundle;
                    n_pos    = 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_bundle <= n_bundle;
        r_out    <= n_out;
        r_last   <= n_last;
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_pos    <= 2'd0;
            r_ovalid <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_pos    <= n_pos;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_valid = r_ovalid;
    assign o_cmd   = r_out;
    assign o_last  = r_last;

    // While a list is in progress the next position is inside it.
    `ASSERT_IMPLIES(a_pos_in_list, i_clk, i_rst_n, r_busy, (r_pos != 2'd0) && (r_pos < r_bundle.cnt))

endmodule

[rtl/panel_brightness_gamma_acl_sequencer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Path: an event transferred in is written into the command queue, and the
// issue part then loads its first command into the output register.
// Throughput: one event per cycle in while the two-entry queue has room; one
// command per cycle out while the receiver is ready, and at most three per event.
// Reset: synchronous, active low; clears the panel state, the queue and output valid.
// ----------------------------------------------------------------------------
// panel_brightness_gamma_acl_sequencer_core
// Brightness, gamma-curve and adaptive current limit command sequencer.
// ----------------------------------------------------------------------------
//
// The design splits into a front part and an issue part:
//
//   pbgas_front  - takes one event per transfer, keeps the applied gamma
//                  level, curve family, limit enable and limit percentage,
//                  and builds combinationally the full list of panel commands
//                  (zero to three) that the event causes. Events that cause
//                  nothing change state only and push nothing.
//   pbgas_queue  - two-entry FIFO of command lists, so that new events keep
//                  flowing while commands are still being issued.
//   pbgas_back   - pops a list and issues its commands in order through an
//                  output register, marking the final one of each list.
//
// Because the front part updates its state at the transfer itself, the next
// event sees the new state at once and back-to-back events are handled
// without any interlock. The input side stalls only when the queue is full.
module panel_brightness_gamma_acl_sequencer_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Event channel.
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_op,
    input  logic [7:0] i_brightness,
    input  logic [7:0] i_setting,
    // Command channel.
    output logic       o_valid,
    input  logic       i_ready,
    output logic [2:0] o_command,
    output logic       o_curve_19,
    output logic [4:0] o_table_index,
    output logic       o_last
);

    pbgas_pkg::t_push  push;
    pbgas_pkg::t_qhead head;
    pbgas_pkg::t_cmd   cmd;
    logic              full;
    logic              pop;

    pbgas_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_op         (i_op),
        .i_brightness (i_brightness),
        .i_setting    (i_setting),
        .i_full       (full),
        .o_push       (push)
    );

    pbgas_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (full),
        .o_head  (head)
    );

    pbgas_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .i_ready (i_ready),
        .o_valid (o_valid),
        .o_cmd   (cmd),
        .o_last  (o_last)
    );

    // Fields of one command transfer.
    assign o_command     = cmd.command;
    assign o_curve_19    = cmd.curve_19;
    assign o_table_index = cmd.table_index;

endmodule

[tb/sv/tb_panel_brightness_gamma_acl_sequencer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Brightness, gamma and current limit sequencer testbench
// Drives brightness, curve and limit events into the sequencer and checks
// every panel command that comes out. A behavioral predictor tracks the
// applied gamma level, curve family, limit enable and limit percentage, and
// queues the commands each event should cause. Both channels idle and stall
// at random, with calm stretches in between.
// ----------------------------------------------------------------------------
module tb_panel_brightness_gamma_acl_sequencer_core;

    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 7;
    localparam int RANDOM_EVENTS = 435;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 400000;

    // The fourth event code is unused by the block and must be ignored.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // One event waiting to be sent. When drain_first is set, the driver holds
    // the event back until every command already expected has been seen.
    typedef struct {
        logic [1:0] op;
        logic [7:0] brightness;
        logic [7:0] setting;
        bit         drain_first;
    } t_panel_event;

    typedef struct packed {
        logic [2:0] command;
        logic       curve_19;
        logic [4:0] table_index;
        logic       last;
    } t_panel_cmd;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_valid       = 1'b0;
    logic [1:0] i_op          = '0;
    logic [7:0] i_brightness  = '0;
    logic [7:0] i_setting     = '0;
    logic       i_ready       = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [2:0] o_command;
    logic       o_curve_19;
    logic [4:0] o_table_index;
    logic       o_last;

    panel_brightness_gamma_acl_sequencer_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_op          (i_op),
        .i_brightness  (i_brightness),
        .i_setting     (i_setting),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_command     (o_command),
        .o_curve_19    (o_curve_19),
        .o_table_index (o_table_index),
        .o_last        (o_last)
    );

    t_panel_event pending_events[$];
    t_panel_cmd   expected_cmds[$];

    // Shadow of the panel state, updated at each accepted event transfer.
    bit         gamma_applied;
    logic [4:0] applied_level;
    logic [5:0] acl_percent;
    logic       curve_sel;
    logic       acl_on;

    int unsigned cycles;
    int unsigned failures;
    int unsigned n_bright;
    int unsigned n_curve;
    int unsigned n_limit;
    int unsigned n_ignored;
    int unsigned n_checked;
    int unsigned n_offs;
    int unsigned send_gap;
    int unsigned stall_left;

    // Calm windows: the sender starts no new idle gap in the first one, the
    // receiver starts no new stall in the second, and the two overlap so that
    // both can run flat out for a while in every period of the cycle count.
    wire calm_tx = (cycles % 1024) < 200;
    wire calm_rx = ((cycles % 1024) >= 100) && ((cycles % 1024) < 300);

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Mostly back to back, often a short gap, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end else if (roll < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 40);
    endfunction

    function automatic t_panel_cmd panel_cmd(input logic [2:0] cmd, input logic curve,
                                             input logic [4:0] idx);
        t_panel_cmd c;
        c.command     = cmd;
        c.curve_19    = curve;
        c.table_index = idx;
        c.last        = 1'b0;
        return c;
    endfunction

    // Linear map of 30..255 onto levels 1..24, computed in tenths of a level
    // with truncating division and then rounded to the nearest level.
    function automatic logic [4:0] gamma_level_for(input logic [7:0] b);
        int scale;
        int span;
        int tenths;
        scale  = 10 * (pbgas_pkg::MAX_GAMMA_INDEX - 1);
        span   = pbgas_pkg::BL_MAX - pbgas_pkg::BL_MIN;
        tenths = (scale * int'(b)) / span + 10 - (scale * pbgas_pkg::BL_MIN) / span;
        if (tenths < 0) begin
            tenths = 0;
        end
        return 5'((tenths + 5) / 10);
    endfunction

    // Limit percentage and cutoff table for a gamma level. Without an applied
    // gamma the widest setting is used.
    function automatic void acl_cutoff_for(input bit have_level, input logic [4:0] lvl,
                                           output logic [5:0] pct, output logic [4:0] idx);
        pct = 6'd50;
        idx = 5'd13;
        if (have_level) begin
            case (lvl)
                5'd0, 5'd1: begin
                    pct = pbgas_pkg::PCT_DIM;
                    idx = pbgas_pkg::IDX_DIM;
                end
                5'd13: begin
                    pct = 6'd43;
                    idx = 5'd16;
                end
                5'd14: begin
                    pct = 6'd45;
                    idx = 5'd10;
                end
                5'd15: begin
                    pct = 6'd47;
                    idx = 5'd11;
                end
                5'd16: begin
                    pct = 6'd48;
                    idx = 5'd12;
                end
                default: begin
                    if (lvl <= 5'd12) begin
                        pct = 6'd40;
                        idx = 5'd9;
                    end
                end
            endcase
        end
    endfunction

    // Applies one accepted event to the shadow state and queues the commands
    // it causes, with the final one of the list marked.
    task automatic predict_event(input logic [1:0] op, input logic [7:0] b,
                                 input logic [7:0] s);
        t_panel_cmd cmds[$];
        logic [4:0] lvl;
        logic [5:0] pct;
        logic [4:0] idx;
        case (op)
            pbgas_pkg::OP_BRIGHT: begin
                n_bright++;
                if (b == 8'd0) begin
                    // Zero brightness always turns the display off and forgets
                    // the applied gamma.
                    gamma_applied = 1'b0;
                    cmds.push_back(panel_cmd(pbgas_pkg::CMD_OFF, 1'b0, 5'd0));
                end else begin
                    lvl = (b < pbgas_pkg::BL_MIN) ? 5'd0 : gamma_level_for(b);
                    if (!(gamma_applied && applied_level == lvl)) begin
                        if (b < pbgas_pkg::BL_MIN) begin
                            // Dimming: the limit is set up before the table.
                            if (acl_on) begin
                                if (acl_percent == pbgas_pkg::PCT_OFF) begin
                                    cmds.push_back(panel_cmd(pbgas_pkg::CMD_INIT,
                                                             1'b0, 5'd0));
                                end
                                if (acl_percent != pbgas_pkg::PCT_DIM) begin
                                    cmds.push_back(panel_cmd(pbgas_pkg::CMD_CUTOFF,
                                                             1'b0, pbgas_pkg::IDX_DIM));
                                    acl_percent = pbgas_pkg::PCT_DIM;
                                end
                            end
                            cmds.push_back(panel_cmd(pbgas_pkg::CMD_TABLE, curve_sel, 5'd0));
                        end else begin
                            cmds.push_back(panel_cmd(pbgas_pkg::CMD_TABLE, curve_sel, lvl));
                            if (acl_on) begin
                                if (acl_percent == pbgas_pkg::PCT_OFF) begin
                                    cmds.push_back(panel_cmd(pbgas_pkg::CMD_INIT,
                                                             1'b0, 5'd0));
                                end
                                acl_cutoff_for(1'b1, lvl, pct, idx);
                                if (acl_percent != pct) begin
                                    cmds.push_back(panel_cmd(pbgas_pkg::CMD_CUTOFF,
                                                             1'b0, idx));
                                    acl_percent = pct;
                                end
                            end
                        end
                        applied_level = lvl;
                        gamma_applied = 1'b1;
                    end
                end
            end
            pbgas_pkg::OP_CURVE: begin
                n_curve++;
                if (s <= 8'd1 && s[0] != curve_sel) begin
                    curve_sel = s[0];
                    if (gamma_applied) begin
                        cmds.push_back(panel_cmd(pbgas_pkg::CMD_TABLE, curve_sel,
                                                 applied_level));
                        cmds.push_back(panel_cmd(pbgas_pkg::CMD_UPDATE, 1'b0, 5'd0));
                    end
                end
            end
            pbgas_pkg::OP_LIMIT: begin
                n_limit++;
                if (s <= 8'd1 && s[0] != acl_on) begin
                    acl_on = s[0];
                    if (s[0]) begin
                        cmds.push_back(panel_cmd(pbgas_pkg::CMD_INIT, 1'b0, 5'd0));
                        acl_cutoff_for(gamma_applied, applied_level, pct, idx);
                        cmds.push_back(panel_cmd(pbgas_pkg::CMD_CUTOFF, 1'b0, idx));
                        acl_percent = pct;
                    end else begin
                        cmds.push_back(panel_cmd(pbgas_pkg::CMD_CUTOFF, 1'b0,
                                                 pbgas_pkg::IDX_OFF));
                        acl_percent = pbgas_pkg::PCT_OFF;
                    end
                end
            end
            default: begin
                n_ignored++;
            end
        endcase
        if (cmds.size() != 0) begin
            cmds[cmds.size() - 1].last = 1'b1;
        end
        foreach (cmds[k]) begin
            expected_cmds.push_back(cmds[k]);
        end
    endtask

    task automatic add_event(input logic [1:0] op, input logic [7:0] b, input logic [7:0] s,
                             input bit drain_first);
        t_panel_event ev;
        ev.op          = op;
        ev.brightness  = b;
        ev.setting     = s;
        ev.drain_first = drain_first;
        pending_events.push_back(ev);
    endtask

    // Random events. Settings are mostly 0 or 1 so that curve and limit
    // changes happen often; the rest are random bytes, mostly out-of-range values
    // that the block must ignore. The event halfway through waits for a full drain.
    task automatic add_random_events(input int unsigned count);
        int unsigned roll;
        logic [1:0]  op;
        logic [7:0]  b;
        logic [7:0]  s;
        for (int unsigned k = 0; k < count; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 50) begin
                op = pbgas_pkg::OP_BRIGHT;
            end else if (roll < 70) begin
                op = pbgas_pkg::OP_CURVE;
            end else if (roll < 92) begin
                op = pbgas_pkg::OP_LIMIT;
            end else begin
                op = OP_UNUSED;
            end
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                b = 8'd0;
            end else if (roll < 22) begin
                b = 8'($urandom_range(1, pbgas_pkg::BL_MIN - 1));
            end else if (roll < 27) begin
                b = ($urandom_range(0, 1) != 0) ? 8'(pbgas_pkg::BL_MAX)
                                                : 8'(pbgas_pkg::BL_MIN);
            end else begin
                b = 8'($urandom);
            end
            s = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 1));
            add_event(op, b, s, k == count / 2);
        end
    endtask

    // Event driver: presents the head of the pending queue, keeps valid and
    // the payload steady until the transfer, and predicts at the transfer.
    always @(posedge i_clk) begin : event_driver
        t_panel_event nxt;
        bit           holding;
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            send_gap = 0;
        end else begin
            holding = i_valid && !o_ready;
            if (i_valid && o_ready) begin
                predict_event(i_op, i_brightness, i_setting);
                send_gap = calm_tx ? 0 : pick_gap();
            end
            if (!holding) begin
                if (send_gap != 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (pending_events.size() != 0 &&
                             !(pending_events[0].drain_first && expected_cmds.size() != 0)) begin
                    nxt = pending_events.pop_front();
                    i_valid      <= 1'b1;
                    i_op         <= nxt.op;
                    i_brightness <= nxt.brightness;
                    i_setting    <= nxt.setting;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Command receiver back-pressure: random stalls outside the calm window.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready    <= 1'b0;
            stall_left = 0;
        end else begin
            if (stall_left == 0 && !calm_rx && $urandom_range(0, 99) < 20) begin
                stall_left = pick_gap();
            end
            if (stall_left != 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Command monitor: every command transfer is matched against the oldest
    // expected command, field by field.
    always @(posedge i_clk) begin : command_monitor
        t_panel_cmd want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_cmds.size() == 0) begin
                $error("unexpected command transfer: command %0d", o_command);
                failures++;
            end else begin
                want = expected_cmds.pop_front();
                n_checked++;
                if (want.command == pbgas_pkg::CMD_OFF) begin
                    n_offs++;
                end
                if (o_command !== want.command) begin
                    $error("command: expected %0d, got %0d", want.command, o_command);
                    failures++;
                end
                if (o_curve_19 !== want.curve_19) begin
                    $error("curve_19: expected %0d, got %0d", want.curve_19, o_curve_19);
                    failures++;
                end
                if (o_table_index !== want.table_index) begin
                    $error("table_index: expected %0d, got %0d",
                           want.table_index, o_table_index);
                    failures++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_last);
                    failures++;
                end
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        gamma_applied = 1'b0;
        applied_level = '0;
        acl_percent   = pbgas_pkg::PCT_OFF;
        curve_sel     = 1'b0;
        acl_on        = 1'b0;

        // Directed part. Starting from reset: display off, a curve change and
        // a limit enable with no gamma applied, the brightness extremes, a
        // repeated level, dimming, each cutoff band, a curve change with a
        // gamma applied, repeated and out-of-range settings, the unused event
        // code, limit off, and limit on from the dimmed level.
        add_event(pbgas_pkg::OP_BRIGHT, 8'd0,   8'd0,   1'b0);
        add_event(pbgas_pkg::OP_CURVE,  8'd0,   8'd1,   1'b0);
        add_event(pbgas_pkg::OP_LIMIT,  8'd0,   8'd1,   1'b0);
        add_event(pbgas_pkg::OP_BRIGHT, 8'd255, 8'd0,   1'b0);
        add_event(pbgas_pkg::OP_BRIGHT, 8'd255, 8'd0,   1'b0);
        add_event(pbgas_pkg::OP_BRIGHT, 8'd1,   8'd0,   1'b0);
        add_event(pbgas_pkg::OP_BRIGHT, 8'd29,  8'd0,   1'b0);
        add_event(pbgas_pkg::OP_BRIGHT, 8'd30,  8'd0,   1'b0);
        add_event(pbgas_pkg::OP_BRIGHT, 8'd40,  8'd0,   1'b0);
        add_event(pbgas_pkg::OP_BRIGHT, 8'd142, 8'd0,   1'b0);
        add_event(pbgas_pkg::OP_BRIGHT, 8'd152, 8'd0,   1'b0);
        add_event(pbgas_pkg::OP_BRIGHT, 8'd162, 8'd0,   1'b0);
        add_event(pbgas_pkg::OP_BRIGHT, 8'd172, 8'd0,   1'b0);
        add_event(pbgas_pkg::OP_BRIGHT, 8'd182, 8'd0,   1'b0);
        add_event(pbgas_pkg::OP_CURVE,  8'd0,   8'd0,   1'b0);
        add_event(pbgas_pkg::OP_CURVE,  8'd0,   8'd0,   1'b0);
        add_event(pbgas_pkg::OP_CURVE,  8'd0,   8'd2,   1'b0);
        add_event(pbgas_pkg::OP_LIMIT,  8'd0,   8'd255, 1'b0);
        add_event(OP_UNUSED,            8'd255, 8'd255, 1'b0);
        add_event(pbgas_pkg::OP_LIMIT,  8'd0,   8'd0,   1'b0);
        add_event(pbgas_pkg::OP_BRIGHT, 8'd1,   8'd0,   1'b1);
        add_event(pbgas_pkg::OP_LIMIT,  8'd0,   8'd1,   1'b0);
        add_event(pbgas_pkg::OP_BRIGHT, 8'd0,   8'd0,   1'b0);
        add_event(pbgas_pkg::OP_CURVE,  8'd0,   8'd1,   1'b0);
        add_event(pbgas_pkg::OP_BRIGHT, 8'd128, 8'd0,   1'b0);
        add_random_events(RANDOM_EVENTS);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every event has been transferred and every expected
        // command has been seen, then give the block time to show any extra.
        do begin
            @(posedge i_clk);
        end while (pending_events.size() != 0 || i_valid || expected_cmds.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Events: %0d brightness, %0d curve, %0d limit, %0d unused code.",
                 n_bright, n_curve, n_limit, n_ignored);
        $display("Commands checked: %0d, of them %0d display off, in %0d cycles.",
                 n_checked, n_offs, cycles);
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/pbgas_pkg.sv
rtl/pbgas_front.sv
rtl/pbgas_queue.sv
rtl/pbgas_back.sv
rtl/panel_brightness_gamma_acl_sequencer_core.sv
tb/sv/tb_panel_brightness_gamma_acl_sequencer_core.sv
